// ===== rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the WebSocket frame deframer
// Frame classes, header field constants and the result record passed
// from the parser to the output stage.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LenW = 63;

  localparam logic [2:0] CLS_TEXT       = 3'd0;
  localparam logic [2:0] CLS_TEXT_FRAG  = 3'd1;
  localparam logic [2:0] CLS_BIN        = 3'd2;
  localparam logic [2:0] CLS_BIN_FRAG   = 3'd3;
  localparam logic [2:0] CLS_PING       = 3'd4;
  localparam logic [2:0] CLS_PONG       = 3'd5;
  localparam logic [2:0] CLS_ERROR      = 3'd6;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;

  localparam logic [3:0] HDR_BASE  = 4'd2;
  localparam logic [3:0] EXT16_LEN = 4'd2;
  localparam logic [3:0] EXT64_LEN = 4'd8;
  localparam logic [3:0] KEY_LEN   = 4'd4;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            has_data;
    logic [2:0]      frame_class;
    logic            last_of_frame;
    logic [LenW-1:0] payload_size;
    logic [3:0]      header_length;
  } result_t;

  function automatic logic [2:0] classify(input logic [7:0] b0);
    logic [3:0] op;
    logic       fin;
    op  = b0[3:0];
    fin = b0[7];
    priority if (op == OP_CONT || op == OP_TEXT) classify = fin ? CLS_TEXT : CLS_TEXT_FRAG;
    else if (op == OP_BIN)  classify = fin ? CLS_BIN : CLS_BIN_FRAG;
    else if (op == OP_PING) classify = CLS_PING;
    else if (op == OP_PONG) classify = CLS_PONG;
    else                    classify = CLS_ERROR;
  endfunction

endpackage

// ===== rtl/wsd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser: per-byte frame header parser and payload unmasker
// Walks the header one byte per accepted transaction and unmasks payload
// bytes; gives at most one result in the cycle the byte is taken.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       byte_in,
  output logic             res_valid,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_MASKKEY,
    PH_PAYLOAD
  } phase_t;

  phase_t          phase, phase_next;
  logic [3:0]      hdr_left, hdr_left_next;   // header bytes still to come in this phase
  logic [2:0]      fclass, fclass_next;
  logic            masked, masked_next;
  logic [LenW-1:0] flen, flen_next;
  logic [31:0]     key, key_next;             // current key byte sits in [31:24]
  logic [LenW-1:0] remaining, remaining_next;
  logic [3:0]      hlen, hlen_next;

  logic [3:0]      ext_len;
  logic            hdr_done;

  always_comb begin
    phase_next     = phase;
    hdr_left_next  = hdr_left;
    fclass_next    = fclass;
    masked_next    = masked;
    flen_next      = flen;
    key_next       = key;
    remaining_next = remaining;
    hlen_next      = hlen;
    ext_len        = '0;
    hdr_done       = 1'b0;
    res_valid      = 1'b0;
    res.data_byte      = '0;
    res.has_data       = 1'b0;
    res.last_of_frame  = 1'b0;

    unique case (phase)
      PH_FIRST: begin
        fclass_next = classify(byte_in);
        masked_next = 1'b0;
        flen_next   = '0;
        key_next    = '0;
        hlen_next   = HDR_BASE;
        phase_next  = PH_SECOND;
      end
      PH_SECOND: begin
        masked_next = byte_in[7];
        if (byte_in[6:0] <= LEN_MAX_SHORT) begin
          flen_next = LenW'(byte_in[6:0]);
          ext_len   = '0;
        end else if (byte_in[6:0] == LEN_EXT16) begin
          flen_next = '0;
          ext_len   = EXT16_LEN;
        end else begin
          flen_next = '0;
          ext_len   = EXT64_LEN;
        end
        hlen_next = HDR_BASE + ext_len + (byte_in[7] ? KEY_LEN : 4'd0);
        if (ext_len != 4'd0) begin
          phase_next    = PH_EXTLEN;
          hdr_left_next = ext_len;
        end else if (byte_in[7]) begin
          phase_next    = PH_MASKKEY;
          hdr_left_next = KEY_LEN;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        flen_next     = {flen[LenW-9:0], byte_in};
        hdr_left_next = hdr_left - 4'd1;
        if (hdr_left == 4'd1) begin
          if (masked) begin
            phase_next    = PH_MASKKEY;
            hdr_left_next = KEY_LEN;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_MASKKEY: begin
        key_next      = {key[23:0], byte_in};
        hdr_left_next = hdr_left - 4'd1;
        if (hdr_left == 4'd1) hdr_done = 1'b1;
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.has_data      = 1'b1;
        res.data_byte     = byte_in ^ key[31:24];
        res.last_of_frame = (remaining == LenW'(1));
        remaining_next    = remaining - LenW'(1);
        key_next          = {key[23:0], key[31:24]};
        if (remaining == LenW'(1)) phase_next = PH_FIRST;
      end
      default: phase_next = PH_FIRST;
    endcase

    if (hdr_done) begin
      remaining_next = flen_next;
      if (flen_next == '0) begin
        // empty frame: one result with no data
        res_valid         = 1'b1;
        res.last_of_frame = 1'b1;
        phase_next        = PH_FIRST;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end

    res.frame_class    = fclass_next;
    res.payload_size   = flen_next;
    res.header_length  = hlen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      hdr_left  <= '0;
      fclass    <= '0;
      masked    <= 1'b0;
      flen      <= '0;
      key       <= '0;
      remaining <= '0;
      hlen      <= '0;
    end else if (take) begin
      phase     <= phase_next;
      hdr_left  <= hdr_left_next;
      fclass    <= fclass_next;
      masked    <= masked_next;
      flen      <= flen_next;
      key       <= key_next;
      remaining <= remaining_next;
      hlen      <= hlen_next;
    end
  end

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top: WebSocket frame deframer
// Channel  Direction  Payload
// in       sink       stream_byte
// out      source     data_byte, has_data, frame_class, last_of_frame,
//                     payload_size, header_length
//
// One stream byte per cycle while in_stall is low. Each result is registered
// in the output register, or in the skid entry while the output is held, so
// input can continue while a result waits; in_stall rises only when both
// entries are full. Synchronous reset returns the parser to the first
// header byte and empties the two-entry output stage.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        has_data,
  output logic [2:0]  frame_class,
  output logic        last_of_frame,
  output logic [62:0] payload_size,
  output logic [3:0]  header_length
);
  import wsd_pkg::*;

  logic    take;
  logic    res_valid;
  result_t res;

  logic    out_full;
  result_t out_reg;
  logic    skid_full;
  result_t skid_reg;
  logic    pop;

  assign in_stall = skid_full;
  assign take     = in_valid && !skid_full;
  assign pop      = out_full && !out_stall;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .byte_in   (stream_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_full && !pop) begin
      // output held: park a new result in the skid entry
      if (take && res_valid) begin
        skid_full <= 1'b1;
        skid_reg  <= res;
      end
    end else if (skid_full) begin
      out_full  <= 1'b1;
      out_reg   <= skid_reg;
      skid_full <= 1'b0;
    end else begin
      out_full <= take && res_valid;
      if (take && res_valid) out_reg <= res;
    end
  end

  assign out_valid      = out_full;
  assign data_byte      = out_reg.data_byte;
  assign has_data       = out_reg.has_data;
  assign frame_class    = out_reg.frame_class;
  assign last_of_frame  = out_reg.last_of_frame;
  assign payload_size   = out_reg.payload_size;
  assign header_length  = out_reg.header_length;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: WebSocket frame deframer
// Feeds a byte stream of WebSocket frames (all opcodes, short/16-bit/64-bit
// lengths, masked and unmasked, empty frames) under random sender gaps and
// receiver stalls. A scoreboard rebuilds each frame from the accepted bytes
// and checks every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import wsd_pkg::*;

  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam int         RANDOM_BYTES = 1900;
  localparam int         TIMEOUT_NS   = 5_000_000;

  typedef enum logic [1:0] {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  class deframe_scoreboard;
    typedef enum logic [2:0] {
      PH_HDR0, PH_HDR1, PH_EXTLEN, PH_KEY, PH_PAYLOAD
    } parse_phase_t;

    result_t         expected_deframed[$];
    int              fault_count;
    int              result_count;
    parse_phase_t    phase;
    logic [3:0]      hdr_seen;
    logic [3:0]      hdr_total;
    logic [3:0]      ext_len;
    logic [7:0]      hdr0;
    logic            masked;
    logic [LenW-1:0] frame_len;
    logic [LenW-1:0] remaining;
    logic [31:0]     key;
    logic [1:0]      key_idx;

    function new();
      phase        = PH_HDR0;
      hdr_seen     = '0;
      hdr_total    = '0;
      ext_len      = '0;
      hdr0         = '0;
      masked       = 1'b0;
      frame_len    = '0;
      remaining    = '0;
      key          = '0;
      key_idx      = '0;
      fault_count  = 0;
      result_count = 0;
    endfunction

    function int pending();
      return expected_deframed.size();
    endfunction

    function logic [2:0] class_of_frame();
      case (hdr0[3:0])
        OP_CONT, OP_TEXT: return hdr0[7] ? CLS_TEXT : CLS_TEXT_FRAG;
        OP_BIN:           return hdr0[7] ? CLS_BIN : CLS_BIN_FRAG;
        OP_PING:          return CLS_PING;
        OP_PONG:          return CLS_PONG;
        default:          return CLS_ERROR;
      endcase
    endfunction

    function void push_result(logic [7:0] d, logic has, logic last);
      result_t r;
      r.data_byte      = d;
      r.has_data       = has;
      r.frame_class    = class_of_frame();
      r.last_of_frame  = last;
      r.payload_size   = frame_len;
      r.header_length  = hdr_total;
      expected_deframed = {expected_deframed, r};
    endfunction

    function void close_header();
      remaining = frame_len;
      key_idx   = '0;
      if (frame_len == '0) begin
        push_result(8'h00, 1'b0, 1'b1);
        phase = PH_HDR0;
      end else begin
        phase = PH_PAYLOAD;
      end
    endfunction

    // advance the parser by one accepted stream byte
    function void take_stream_byte(logic [7:0] b);
      logic [7:0] kb;
      case (phase)
        PH_HDR0: begin
          hdr0      = b;
          hdr_seen  = 4'd1;
          masked    = 1'b0;
          frame_len = '0;
          key       = '0;
          remaining = '0;
          key_idx   = '0;
          hdr_total = HDR_BASE;
          phase     = PH_HDR1;
        end
        PH_HDR1: begin
          masked = b[7];
          if (b[6:0] <= LEN_MAX_SHORT) begin
            frame_len = LenW'(b[6:0]);
            ext_len   = '0;
          end else if (b[6:0] == LEN_EXT16) begin
            frame_len = '0;
            ext_len   = EXT16_LEN;
          end else begin
            frame_len = '0;
            ext_len   = EXT64_LEN;
          end
          hdr_total = HDR_BASE + ext_len + (masked ? KEY_LEN : 4'd0);
          hdr_seen  = 4'd2;
          if (ext_len != '0) phase = PH_EXTLEN;
          else if (masked) phase = PH_KEY;
          else close_header();
        end
        PH_EXTLEN: begin
          // top bit of a 64-bit length falls off the 63-bit register
          frame_len = {frame_len[LenW-9:0], b};
          hdr_seen  = hdr_seen + 4'd1;
          if (hdr_seen == HDR_BASE + ext_len) begin
            if (masked) phase = PH_KEY;
            else close_header();
          end
        end
        PH_KEY: begin
          key      = {key[23:0], b};
          hdr_seen = hdr_seen + 4'd1;
          if (hdr_seen == hdr_total) close_header();
        end
        PH_PAYLOAD: begin
          kb        = 8'(key >> (24 - 8 * int'(key_idx)));
          remaining = remaining - 1'b1;
          push_result(b ^ kb, 1'b1, remaining == '0);
          key_idx = key_idx + 2'd1;
          if (remaining == '0) phase = PH_HDR0;
        end
        default: phase = PH_HDR0;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: result %0d: %s", $time, result_count, msg);
      fault_count++;
    endtask

    task check_deframed(result_t got);
      result_t want;
      result_count++;
      if (expected_deframed.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction %h", got));
        return;
      end
      want = expected_deframed.pop_front();
      if (got.data_byte !== want.data_byte)
        report_mismatch($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
      if (got.has_data !== want.has_data)
        report_mismatch($sformatf("has_data %b, want %b", got.has_data, want.has_data));
      if (got.frame_class !== want.frame_class)
        report_mismatch($sformatf("frame_class %0d, want %0d",
                                  got.frame_class, want.frame_class));
      if (got.last_of_frame !== want.last_of_frame)
        report_mismatch($sformatf("last_of_frame %b, want %b",
                                  got.last_of_frame, want.last_of_frame));
      if (got.payload_size !== want.payload_size)
        report_mismatch($sformatf("payload_size %h, want %h",
                                  got.payload_size, want.payload_size));
      if (got.header_length !== want.header_length)
        report_mismatch($sformatf("header_length %0d, want %0d",
                                  got.header_length, want.header_length));
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      stream_byte = 8'h00;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [7:0]      data_byte;
  logic            has_data;
  logic [2:0]      frame_class;
  logic            last_of_frame;
  logic [LenW-1:0] payload_size;
  logic [3:0]      header_length;

  deframe_scoreboard sb;
  int                send_idle_pct  = 26;
  int                recv_stall_pct = 50;
  int                bytes_sent     = 0;

  websocket_frame_deframer_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .stream_byte    (stream_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_byte      (data_byte),
    .has_data       (has_data),
    .frame_class    (frame_class),
    .last_of_frame  (last_of_frame),
    .payload_size   (payload_size),
    .header_length  (header_length)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // input transaction is noted before the output check of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_stream_byte(stream_byte);
      if (out_valid && !out_stall)
        sb.check_deframed({data_byte, has_data, frame_class, last_of_frame,
                           payload_size, header_length});
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hdr0, input logic masked,
                            input len_form_t form, input logic [63:0] raw_len,
                            input int n_bytes);
    logic [31:0] key;
    key = $urandom;
    send_byte(hdr0);
    case (form)
      FORM_SHORT: send_byte({masked, raw_len[6:0]});
      FORM_EXT16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(raw_len[15:8]);
        send_byte(raw_len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(raw_len[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    repeat (n_bytes) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame();
    logic [7:0]  hdr0;
    logic [3:0]  op;
    logic [63:0] raw_len;
    logic        fin;
    len_form_t   form;
    int          pick;
    fin = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0:       op = OP_CONT;
      1:       op = OP_TEXT;
      2:       op = OP_BIN;
      3:       op = OP_PING;
      default: op = OP_PONG;
    endcase
    hdr0 = {fin, 3'b000, op};
    // some headers are raw noise: reserved bits, unknown opcodes
    if ($urandom_range(0, 99) < 20) hdr0 = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      form    = FORM_SHORT;
      raw_len = ($urandom_range(0, 9) == 0) ? 64'(LEN_MAX_SHORT) : 64'($urandom_range(0, 24));
    end else if (pick < 85) begin
      form    = FORM_EXT16;
      raw_len = 64'($urandom_range(0, 300));
    end else begin
      form        = FORM_EXT64;
      raw_len     = 64'($urandom_range(0, 40));
      raw_len[63] = 1'($urandom_range(0, 1));
    end
    send_frame(hdr0, 1'($urandom_range(0, 1)), form, raw_len, int'(raw_len[15:0]));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames
    send_frame(8'h81, 1'b0, FORM_SHORT, 64'd0, 0);                 // empty text
    send_frame(8'h00, 1'b1, FORM_SHORT, 64'd1, 1);                 // continuation
    send_frame(8'h82, 1'b0, FORM_EXT16, 64'd0, 0);                 // zero 16-bit length
    send_frame(8'h72, 1'b0, FORM_EXT64, 64'h8000_0000_0000_0002, 2); // top bit dropped
    send_frame(8'h09, 1'b1, FORM_SHORT, 64'd0, 0);                 // masked empty ping
    send_frame(8'h8A, 1'b0, FORM_SHORT, 64'd1, 1);                 // pong
    send_frame(8'h8F, 1'b0, FORM_SHORT, 64'd0, 0);                 // unknown opcode
    send_frame(8'h03, 1'b1, FORM_EXT16, 64'd3, 3);                 // unknown, with data
    send_frame(8'hFF, 1'b1, FORM_SHORT, 64'd2, 2);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 26; recv_stall_pct = 50; end
        1:       begin send_idle_pct = 50; recv_stall_pct = 26; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      while (bytes_sent < (ph + 1) * RANDOM_BYTES / 3) send_random_frame();
      drain_results();
    end

    // huge 64-bit length: high length bits reach the output, frame never ends
    send_frame(8'h82, 1'b1, FORM_EXT64, {$urandom, $urandom} | (64'h1 << 40), 24);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer_top.sv
sim/testbench.sv
